[rtl/assert_macros.svh]
// assertion macros for the trend normalizer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequence must hold whenever the antecedent holds, outside reset
`define TWMM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// expression must hold on every clock outside reset
`define TWMM_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`endif

[rtl/twmm_pkg.sv]
// package for the trend window min/max normalizer: sizes, codes, state type
// no dependencies
`default_nettype none

package twmm_pkg;

  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int T_W        = 16;
  localparam int H_W        = 10;
  localparam int PHASE_W    = 4;
  localparam int FULL_SCALE = 1023;
  localparam int ONE_DEGREE = 16;
  localparam int Q_W        = $clog2(FULL_SCALE + 1);
  localparam int PROD_W     = T_W + Q_W;
  localparam int STEP_W     = $clog2(Q_W + 1);
  localparam int OUT_W      = IDX_W + H_W + 2 * T_W;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD,
    S_DIVIDE
  } state_t;

endpackage

`default_nettype wire

[rtl/twmm_cell.sv]
// one storage cell of the sample ring; takes its neighbor's value, or a new sample at the tail, when enabled
// depends on twmm_pkg
`default_nettype none

module twmm_cell
  import twmm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [T_W-1:0] d,
  output logic signed [T_W-1:0]      q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

[rtl/twmm_div.sv]
// serial restoring divider, one quotient bit per cycle
// depends on twmm_pkg; quotient must fit in Q_W bits
`default_nettype none

module twmm_div
  import twmm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [T_W-1:0]    divisor,
  output logic [Q_W-1:0]         quotient,
  output logic                   done
);

  logic [T_W:0]      rem;
  logic [Q_W-1:0]    bits;
  logic [T_W-1:0]    dvs;
  logic [STEP_W-1:0] cnt;
  logic              started;
  logic [T_W:0]      trial;
  logic              fits;

  assign trial    = {rem[T_W-1:0], bits[Q_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = bits;
  assign done     = started && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      started <= 1'b0;
    end else if (start) begin
      cnt     <= STEP_W'(Q_W);
      started <= 1'b1;
    end else if (cnt != '0) begin
      cnt <= cnt - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, dividend[PROD_W-1 -: T_W]};
      bits <= dividend[Q_W-1:0];
      dvs  <= divisor;
    end else if (cnt != '0) begin
      rem  <= fits ? (trial - {1'b0, dvs}) : trial;
      bits <= {bits[Q_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[rtl/trend_window_minmax_normalizer.sv]
// Trend window min/max normalizer. Every sixteenth sample request enters a
// ring of 64 cells; the block then scans the filled cells for min and max
// (one cell per cycle as the ring rotates) and emits 64 points, oldest
// first, each scaled to 0..1023 by a shared one-bit-per-cycle divider.
// A stored sample goes through accept, scan, then a load and a divide step
// per point; a stalled output holds the divide step. A clear request or a
// skipped sample starts no update. Input is accepted only while no update
// is in progress. Uses twmm_pkg, twmm_cell, twmm_div, assert_macros.svh.
`default_nettype none

module trend_window_minmax_normalizer
  import twmm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [T_W-1:0]   s_tdata,   // temperature
  input  wire logic             s_tuser,   // operation
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // point_index, point_height, window_max, window_min
  output logic                  m_tlast    // last_point
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  state_t state, state_next;

  logic [IDX_W-1:0]   step;
  logic [IDX_W-1:0]   offset;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   fill_next;
  logic [PHASE_W-1:0] phase;
  logic signed [T_W-1:0] win_min, win_max, oldest;

  logic accept, is_sample, slot_free;
  logic shift_in, rotate, div_start, push;

  logic signed [T_W-1:0] ring [DEPTH];
  logic signed [T_W-1:0] feed;
  logic signed [T_W-1:0] cur;

  logic signed [T_W-1:0] pt_val;
  logic signed [T_W:0]   diff_w, span_w;
  logic [T_W-1:0]        diff, span, divisor;
  logic [PROD_W-1:0]     dividend;
  logic [Q_W-1:0]        quotient;
  logic                  div_done;

  assign accept    = s_tvalid && s_tready;
  assign is_sample = accept && (op_t'(s_tuser) == OP_SAMPLE) && (phase == '0);
  assign slot_free = !m_tvalid || m_tready;
  assign cur       = ring[0];
  assign feed      = shift_in ? $signed(s_tdata) : cur;
  assign fill_next = (fill_count < CNT_W'(DEPTH)) ? fill_count + CNT_W'(1) : fill_count;

  // ring of cells, cell 0 holds the oldest entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      twmm_cell u_cell (
        .clk (clk),
        .en  (shift_in || rotate),
        .d   (feed),
        .q   (ring[i])
      );
    end else begin : g_body
      twmm_cell u_cell (
        .clk (clk),
        .en  (shift_in || rotate),
        .d   (ring[i+1]),
        .q   (ring[i])
      );
    end
  end

  // point value, offset from min, and span
  assign pt_val   = (step < offset) ? oldest : cur;
  assign diff_w   = (T_W+1)'(pt_val) - (T_W+1)'(win_min);
  assign span_w   = (T_W+1)'(win_max) - (T_W+1)'(win_min);
  assign diff     = diff_w[T_W-1:0];
  assign span     = span_w[T_W-1:0];
  assign divisor  = (span == '0) ? T_W'(ONE_DEGREE) : span;
  assign dividend = PROD_W'(diff) * PROD_W'(FULL_SCALE);

  twmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (is_sample) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step == LAST_IDX) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_done && slot_free) begin
          state_next = (step == LAST_IDX) ? S_IDLE : S_LOAD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    shift_in  = (state == S_IDLE) && is_sample;
    rotate    = (state == S_SCAN) || (state == S_LOAD);
    div_start = (state == S_LOAD);
    push      = (state == S_DIVIDE) && div_done && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      phase      <= '0;
      step       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (op_t'(s_tuser) == OP_CLEAR) begin
          fill_count <= '0;
        end else begin
          phase <= phase + PHASE_W'(1);
          if (shift_in) begin
            fill_count <= fill_next;
          end
        end
      end
      if (shift_in) begin
        step <= '0;
      end else if ((state == S_SCAN) || push) begin
        step <= (step == LAST_IDX) ? '0 : step + IDX_W'(1);
      end
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // scan results and output payload
  always_ff @(posedge clk) begin
    if (shift_in) begin
      offset  <= IDX_W'(CNT_W'(DEPTH) - fill_next);
      win_min <= $signed(s_tdata);
      win_max <= $signed(s_tdata);
    end else if ((state == S_SCAN) && (step >= offset)) begin
      if (cur < win_min) begin
        win_min <= cur;
      end
      if (cur > win_max) begin
        win_max <= cur;
      end
    end
    if ((state == S_SCAN) && (step == offset)) begin
      oldest <= cur;
    end
    if (push) begin
      m_tdata <= {win_min, win_max, H_W'(quotient), step};
      m_tlast <= (step == LAST_IDX);
    end
  end

  `include "assert_macros.svh"

  `TWMM_ASSERT_ALWAYS(a_fill_range, clk, rst, fill_count <= CNT_W'(DEPTH))
  `TWMM_ASSERT_IMP(a_last_index, clk, rst, m_tvalid && m_tlast, m_tdata[IDX_W-1:0] == LAST_IDX)
  `TWMM_ASSERT_IMP(a_max_ge_min, clk, rst, m_tvalid, $signed(m_tdata[IDX_W+H_W +: T_W]) >= $signed(m_tdata[IDX_W+H_W+T_W +: T_W]))

endmodule

`default_nettype wire
